FILE: design/sbc_tile_owner_rank_macros.svh
// ---------------------------------------------------------------------------
// sbc tile owner rank assertion macros
// assertion wrappers for the tile owner lookup checker
// ---------------------------------------------------------------------------
`ifndef SBC_TILE_OWNER_RANK_MACROS_SVH
`define SBC_TILE_OWNER_RANK_MACROS_SVH

// property checked on every edge outside reset
`define SBC_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("%m: check failed");

// property checked on every edge, reset included
`define SBC_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("%m: check failed");

`endif

FILE: design/sbc_pkg.sv
// ---------------------------------------------------------------------------
// sbc_pkg
// types, register indexes and helpers of the tile owner lookup
// ---------------------------------------------------------------------------
`default_nettype none

package sbc_pkg;

   localparam int unsigned TILE_W    = 16;
   localparam int unsigned SUM_W     = TILE_W + 1;
   localparam int unsigned RANK_W    = 15;
   localparam int unsigned PAT_W     = 8;
   localparam int unsigned CSR_IDX_W = 3;
   localparam int unsigned CSR_W     = 16;

   // input reg + two divider pipes + three mapping stages
   localparam int unsigned LATENCY   = 1 + SUM_W + SUM_W + 3;

   localparam logic [CSR_IDX_W-1:0] CSR_PATTERN_SIZE  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_EXTENDED      = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_LOWER_STORAGE = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_DIAG_PATTERNS = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_ROW_OFFSET    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_COL_OFFSET    = 3'd5;

   typedef struct packed {
      logic [PAT_W-1:0] r;
      logic             extended;
   } map_cfg_type;

   typedef struct packed {
      logic [PAT_W-1:0] x;
      logic [PAT_W-1:0] y;
   } pair_type;

   // pairs d with (d + l) mod r
   function automatic pair_type rot_pair(input logic [PAT_W-1:0] d,
                                         input logic [PAT_W-1:0] l,
                                         input logic [PAT_W-1:0] r);
      pair_type     p;
      logic [PAT_W:0] s;
      s = {1'b0, d} + {1'b0, l};
      if ({1'b0, d} < ({1'b0, r} - {1'b0, l})) begin
         p.x = d;
         p.y = s[PAT_W-1:0];
      end else begin
         p.x = PAT_W'(s - {1'b0, r});
         p.y = d;
      end
      return p;
   endfunction

endpackage

`default_nettype wire

FILE: design/sbc_div_pipe.sv
// ---------------------------------------------------------------------------
// sbc_div_pipe
// restoring divider, one quotient bit per register stage
// ---------------------------------------------------------------------------
`default_nettype none

module sbc_div_pipe #(
   parameter int unsigned WIDTH  = 17,
   parameter int unsigned DIV_W  = 8,
   parameter int unsigned SIDE_W = 1
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              in_valid,
   input  wire logic [WIDTH-1:0]  in_num,
   input  wire logic [DIV_W-1:0]  divisor,
   input  wire logic [SIDE_W-1:0] in_side,
   output logic                   out_valid,
   output logic [WIDTH-1:0]       out_quot,
   output logic [DIV_W-1:0]       out_rem,
   output logic [SIDE_W-1:0]      out_side
);

   logic [WIDTH-1:0]  valid_ff;
   logic [WIDTH-1:0]  valid_in;
   logic [DIV_W-1:0]  rem_ff   [WIDTH];
   logic [DIV_W-1:0]  rem_in   [WIDTH];
   logic [WIDTH-1:0]  num_ff   [WIDTH];
   logic [WIDTH-1:0]  num_in   [WIDTH];
   logic [SIDE_W-1:0] side_ff  [WIDTH];
   logic [SIDE_W-1:0] side_in  [WIDTH];

   for (genvar s = 0; s < WIDTH; s++) begin : g_stage
      logic [DIV_W-1:0]  rem_prev;
      logic [WIDTH-1:0]  num_prev;
      logic [DIV_W:0]    trial;
      logic              ge;

      if (s == 0) begin : g_first
         always_comb begin
            rem_prev    = '0;
            num_prev    = in_num;
            valid_in[s] = in_valid;
            side_in[s]  = in_side;
         end
      end else begin : g_next
         always_comb begin
            rem_prev    = rem_ff[s-1];
            num_prev    = num_ff[s-1];
            valid_in[s] = valid_ff[s-1];
            side_in[s]  = side_ff[s-1];
         end
      end

      // dividend bits shift out at the top, quotient bits shift in below
      always_comb begin
         trial     = {rem_prev, num_prev[WIDTH-1]};
         ge        = (trial >= {1'b0, divisor});
         rem_in[s] = ge ? DIV_W'(trial - {1'b0, divisor}) : DIV_W'(trial);
         num_in[s] = {num_prev[WIDTH-2:0], ge};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[s] <= 1'b0;
         end else begin
            valid_ff[s] <= valid_in[s];
         end
         rem_ff[s]  <= rem_in[s];
         num_ff[s]  <= num_in[s];
         side_ff[s] <= side_in[s];
      end
   end

   assign out_valid = valid_ff[WIDTH-1];
   assign out_quot  = num_ff[WIDTH-1];
   assign out_rem   = rem_ff[WIDTH-1];
   assign out_side  = side_ff[WIDTH-1];

endmodule

`default_nettype wire

FILE: design/sbc_rank_map.sv
// ---------------------------------------------------------------------------
// sbc_rank_map
// pattern position to rank: pair select, square, packed index
// ---------------------------------------------------------------------------
`default_nettype none

module sbc_rank_map (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire sbc_pkg::map_cfg_type      cfg,
   input  wire logic                      in_valid,
   input  wire logic                      in_outside,
   input  wire logic [sbc_pkg::PAT_W-1:0] in_a,
   input  wire logic [sbc_pkg::PAT_W-1:0] in_b,
   input  wire logic [sbc_pkg::PAT_W-1:0] in_pat,
   output logic                           out_valid,
   output logic [sbc_pkg::RANK_W-1:0]     out_rank,
   output logic                           out_outside
);
   import sbc_pkg::*;

   logic [PAT_W-1:0] half;
   logic [PAT_W-1:0] normal;
   logic [PAT_W-1:0] am1;
   logic [PAT_W-1:0] am2;
   logic [PAT_W-1:0] sh;
   pair_type         pair;

   logic             v1_ff, v2_ff, v3_ff;
   logic             o1_ff, o2_ff, o3_ff;
   pair_type         pair_ff;
   logic [PAT_W-1:0] lo_in, hi_in;
   logic [PAT_W-1:0] lo_ff;
   logic [2*PAT_W-1:0] prod_in, prod_ff;
   logic [RANK_W-1:0] rank_in, rank_ff;

   // stage 1: choose the pair that owns this position
   always_comb begin
      half   = cfg.r >> 1;
      normal = half - PAT_W'(1);
      sh     = in_pat - normal;
      am1    = (in_a >= half) ? in_a - half : in_a;
      am2    = (am1 >= half) ? am1 - half : am1;
      pair   = '{x: in_a, y: in_b};
      if (in_a == in_b) begin
         if (!cfg.extended) begin
            // round-robin extra ranks sit after the packed ones
            pair = '{x: am2, y: cfg.r};
         end else if (cfg.r[0]) begin
            pair = rot_pair(in_a, in_pat + PAT_W'(1), cfg.r);
         end else if (in_pat < normal) begin
            pair = rot_pair(in_a, in_pat + PAT_W'(1), cfg.r);
         end else if (in_a < half) begin
            pair = '{x: in_a, y: (sh == '0) ? in_a + half : in_a + sh};
         end else if (sh == normal) begin
            pair = '{x: in_a - half, y: in_a};
         end else begin
            pair = rot_pair(in_a, sh + PAT_W'(1), cfg.r);
         end
      end
   end

   // stage 2: hi * (hi - 1)
   always_comb begin
      lo_in   = (pair_ff.x < pair_ff.y) ? pair_ff.x : pair_ff.y;
      hi_in   = (pair_ff.x < pair_ff.y) ? pair_ff.y : pair_ff.x;
      prod_in = (2*PAT_W)'(hi_in) * (2*PAT_W)'(hi_in - PAT_W'(1));
   end

   // stage 3: halve and add lo, zero for positions outside the triangle
   always_comb begin
      rank_in = RANK_W'(prod_ff >> 1) + RANK_W'(lo_ff);
      if (o2_ff) begin
         rank_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
      o1_ff   <= in_outside;
      pair_ff <= pair;
      o2_ff   <= o1_ff;
      lo_ff   <= lo_in;
      prod_ff <= prod_in;
      o3_ff   <= o2_ff;
      rank_ff <= rank_in;
   end

   assign out_valid   = v3_ff;
   assign out_rank    = rank_ff;
   assign out_outside = o3_ff;

endmodule

`default_nettype wire

FILE: design/sbc_tile_owner_rank.sv
// ---------------------------------------------------------------------------
// sbc_tile_owner_rank
// symmetric block-cyclic tile owner lookup, fully pipelined
// ---------------------------------------------------------------------------
//  channel   handshake             payload
//  request   start / busy          req_tile_row, req_tile_col
//  response  rsp_valid (strobe)    rsp_owner_rank, rsp_outside_triangle
//  csr       csr_wr_en             csr_index, csr_wdata
//
//  one item per cycle; each result passes the input register, the two
//  bit-serial divider pipes (m mod r and n div r, then block column mod
//  pattern count) and three mapping stages.
//  busy stays low: the pipe never stalls; the receiver must take every strobe (not enforced).
//  reset clears all valid bits and loads the register defaults.
// ---------------------------------------------------------------------------
`default_nettype none

module sbc_tile_owner_rank (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   output logic                               busy,
   input  wire logic [sbc_pkg::TILE_W-1:0]    req_tile_row,
   input  wire logic [sbc_pkg::TILE_W-1:0]    req_tile_col,
   output logic                               rsp_valid,
   output logic [sbc_pkg::RANK_W-1:0]         rsp_owner_rank,
   output logic                               rsp_outside_triangle,
   input  wire logic                          csr_wr_en,
   input  wire logic [sbc_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [sbc_pkg::CSR_W-1:0]     csr_wdata
);
   import sbc_pkg::*;

   logic [PAT_W-1:0]  pattern_size_ff;
   logic              extended_ff;
   logic              lower_ff;
   logic [PAT_W-1:0]  diag_count_ff;
   logic [TILE_W-1:0] row_off_ff;
   logic [TILE_W-1:0] col_off_ff;

   logic [PAT_W-1:0]  r_eff;
   logic [PAT_W-1:0]  dmax;
   logic [PAT_W-1:0]  dp_eff;
   map_cfg_type       map_cfg;

   logic              s0_valid_ff;
   logic [SUM_W-1:0]  m_ff, n_ff;
   logic [SUM_W-1:0]  m_in, n_in;
   logic              outside_ff, outside_in;

   logic              d1_valid;
   logic              d1_outside;
   logic [PAT_W-1:0]  a_rem;
   logic [PAT_W-1:0]  b_rem;
   logic [SUM_W-1:0]  n_quot;

   logic              d2_valid;
   logic [PAT_W-1:0]  pat_rem;
   logic [2*PAT_W:0]  d2_side;

   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_size_ff <= PAT_W'(2);
         extended_ff     <= 1'b1;
         lower_ff        <= 1'b1;
         diag_count_ff   <= PAT_W'(1);
         row_off_ff      <= '0;
         col_off_ff      <= '0;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_PATTERN_SIZE:  pattern_size_ff <= csr_wdata[PAT_W-1:0];
            CSR_EXTENDED:      extended_ff     <= csr_wdata[0];
            CSR_LOWER_STORAGE: lower_ff        <= csr_wdata[0];
            CSR_DIAG_PATTERNS: diag_count_ff   <= csr_wdata[PAT_W-1:0];
            CSR_ROW_OFFSET:    row_off_ff      <= csr_wdata[TILE_W-1:0];
            CSR_COL_OFFSET:    col_off_ff      <= csr_wdata[TILE_W-1:0];
            default: ;
         endcase
      end
   end

   // effective pattern size and diagonal pattern count
   always_comb begin
      r_eff  = (pattern_size_ff < PAT_W'(2)) ? PAT_W'(2) : pattern_size_ff;
      dmax   = r_eff[0] ? (r_eff >> 1) : r_eff - PAT_W'(1);
      dp_eff = (diag_count_ff == '0) ? PAT_W'(1) : diag_count_ff;
      if (!extended_ff || dp_eff > dmax) begin
         dp_eff = extended_ff ? dmax : dp_eff;
      end
      map_cfg = '{r: r_eff, extended: extended_ff};
   end

   always_comb begin
      m_in       = SUM_W'(req_tile_row) + SUM_W'(row_off_ff);
      n_in       = SUM_W'(req_tile_col) + SUM_W'(col_off_ff);
      outside_in = lower_ff ? (m_in < n_in) : (n_in < m_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
      end else begin
         s0_valid_ff <= start;
      end
      m_ff       <= m_in;
      n_ff       <= n_in;
      outside_ff <= outside_in;
   end

   sbc_div_pipe #(.WIDTH(SUM_W), .DIV_W(PAT_W), .SIDE_W(1)) u_div_row (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s0_valid_ff),
      .in_num    (m_ff),
      .divisor   (r_eff),
      .in_side   (outside_ff),
      .out_valid (d1_valid),
      .out_quot  (),
      .out_rem   (a_rem),
      .out_side  (d1_outside)
   );

   sbc_div_pipe #(.WIDTH(SUM_W), .DIV_W(PAT_W), .SIDE_W(1)) u_div_col (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s0_valid_ff),
      .in_num    (n_ff),
      .divisor   (r_eff),
      .in_side   (1'b0),
      .out_valid (),
      .out_quot  (n_quot),
      .out_rem   (b_rem),
      .out_side  ()
   );

   // block column mod pattern count picks the diagonal pattern
   sbc_div_pipe #(.WIDTH(SUM_W), .DIV_W(PAT_W), .SIDE_W(2*PAT_W+1)) u_div_pat (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (d1_valid),
      .in_num    (n_quot),
      .divisor   (dp_eff),
      .in_side   ({d1_outside, a_rem, b_rem}),
      .out_valid (d2_valid),
      .out_quot  (),
      .out_rem   (pat_rem),
      .out_side  (d2_side)
   );

   sbc_rank_map u_map (
      .clock       (clock),
      .reset       (reset),
      .cfg         (map_cfg),
      .in_valid    (d2_valid),
      .in_outside  (d2_side[2*PAT_W]),
      .in_a        (d2_side[2*PAT_W-1:PAT_W]),
      .in_b        (d2_side[PAT_W-1:0]),
      .in_pat      (pat_rem),
      .out_valid   (rsp_valid),
      .out_rank    (rsp_owner_rank),
      .out_outside (rsp_outside_triangle)
   );

   assign busy = 1'b0;

endmodule

`default_nettype wire

FILE: design/sbc_tile_owner_rank_chk.sv
// ---------------------------------------------------------------------------
// sbc_tile_owner_rank_chk
// port-level checks of the tile owner lookup
// ---------------------------------------------------------------------------
`default_nettype none
`include "sbc_tile_owner_rank_macros.svh"

module sbc_tile_owner_rank_chk (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   input  wire logic                          busy,
   input  wire logic [sbc_pkg::TILE_W-1:0]    req_tile_row,
   input  wire logic [sbc_pkg::TILE_W-1:0]    req_tile_col,
   input  wire logic                          rsp_valid,
   input  wire logic [sbc_pkg::RANK_W-1:0]    rsp_owner_rank,
   input  wire logic                          rsp_outside_triangle,
   input  wire logic                          csr_wr_en,
   input  wire logic [sbc_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [sbc_pkg::CSR_W-1:0]     csr_wdata
);
   import sbc_pkg::*;

   // every strobe answers a start that has run through the whole pipe
   `SBC_ASSERT(a_latency, clock, reset, rsp_valid |-> $past(start, LATENCY))

   `SBC_ASSERT(a_outside_zero, clock, reset,
      rsp_valid && rsp_outside_triangle |-> rsp_owner_rank == '0)

   `SBC_ASSERT_ALWAYS(a_reset_flush, clock, reset |=> !rsp_valid)

   `SBC_ASSERT_ALWAYS(a_never_busy, clock, !busy)

endmodule

bind sbc_tile_owner_rank sbc_tile_owner_rank_chk u_chk (.*);

`default_nettype wire
